// File: rtl/core/psmd_pkg.sv
// Shared constants, types and register codes for the split-drive PID controller.
`default_nettype none

package psmd_pkg;

  localparam int SPEED_LIMIT    = 30;
  localparam int GAIN_FRAC_BITS = 12;

  localparam int GAIN_W    = 16;
  localparam int ANGLE_W   = 11;
  localparam int ERR_W     = ANGLE_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int SUM_W     = 32;
  localparam int SPEED_W   = 5;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = GAIN_W;

  localparam int PK_W   = GAIN_W + ERR_W + 1;
  localparam int PD_W   = GAIN_W + DIFF_W + 1;
  localparam int PI_W   = GAIN_W + SUM_W;
  localparam int A_W    = PD_W + 5;
  localparam int MAG_W  = PI_W - 1;
  localparam int BIG_LO = 40;
  localparam int HALF_W = (BIG_LO - 2) / 2;
  localparam int QH_W   = HALF_W - 2;
  localparam int Q_W    = QH_W + HALF_W;
  localparam int T_W    = HALF_W + 3;
  localparam int DRV_W  = Q_W + 2;
  localparam int MAGH_W = DRV_W - GAIN_FRAC_BITS;

  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 26;
  localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'(((1 << RECIP_SH) + 1) / 5);

  localparam int NSTG = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP     = 8'd0,
    REG_KI     = 8'd1,
    REG_KD     = 8'd2,
    REG_TARGET = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [GAIN_W-1:0]         kd;
    logic signed [ANGLE_W-1:0] target;
  } cfg_t;

  typedef struct packed {
    logic [NSTG-1:0] vld;
    logic [NSTG-1:0] ld;
  } pipe_ctl_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]  e;
    logic signed [DIFF_W-1:0] d;
    logic signed [SUM_W-1:0]  s;
  } stg1_t;

  typedef struct packed {
    logic signed [PK_W-1:0] pk;
    logic signed [PD_W-1:0] pd;
    logic signed [PI_W-1:0] pi;
  } stg2_t;

  typedef struct packed {
    logic signed [A_W-1:0] a;
    logic                  neg;
    logic                  big;
    logic [Q_W-1:0]        q;
  } stg4_t;

endpackage

`default_nettype wire

// File: rtl/core/pid_split_motor_drive.sv
// PID angle controller top level: handshake, pipeline control and stage wiring.
// Throughput: one beat per cycle unless out_stall holds the result, set by the
// seven-stage pipeline (input register, error stage, multipliers, two divide-by-20
// stages, drive sum, speed register).
// Reset: synchronous active-low rst_n restores default gains and setpoint 90,
// clears the error sum, the previous error and all pipeline valids.
`default_nettype none

module pid_split_motor_drive (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [psmd_pkg::ANGLE_W-1:0] in_measured_angle,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [psmd_pkg::SPEED_W-1:0]             out_front_speed,
  output logic [psmd_pkg::SPEED_W-1:0]             out_back_speed,
  input  wire logic                                cfg_wr_en,
  input  wire logic [psmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [psmd_pkg::CFG_W-1:0]          cfg_data
);

  logic [psmd_pkg::NSTG-1:0]          vld_r;
  logic [psmd_pkg::NSTG-1:0]          rdy;
  logic signed [psmd_pkg::ANGLE_W-1:0] ang_r;
  psmd_pkg::pipe_ctl_t                ctl;
  psmd_pkg::cfg_t                     cfg;
  psmd_pkg::stg1_t                    s1;
  psmd_pkg::stg2_t                    s2;
  psmd_pkg::stg4_t                    s4;

  always_comb begin
    rdy[psmd_pkg::NSTG-1] = ~vld_r[psmd_pkg::NSTG-1] | ~out_stall;
    for (int k = psmd_pkg::NSTG - 2; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign ctl.vld = vld_r;
  assign ctl.ld  = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < psmd_pkg::NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ang_r <= in_measured_angle;
    end
  end

  psmd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psmd_err u_err (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .ang    (ang_r),
    .target (cfg.target),
    .s1     (s1)
  );

  psmd_mul u_mul (
    .clk (clk),
    .ctl (ctl),
    .cfg (cfg),
    .s1  (s1),
    .s2  (s2)
  );

  psmd_div u_div (
    .clk (clk),
    .ctl (ctl),
    .s2  (s2),
    .s4  (s4)
  );

  psmd_drv u_drv (
    .clk         (clk),
    .ctl         (ctl),
    .s4          (s4),
    .front_speed (out_front_speed),
    .back_speed  (out_back_speed)
  );

  assign in_stall  = ~rdy[0];
  assign out_valid = vld_r[psmd_pkg::NSTG-1];

endmodule

`default_nettype wire

// File: rtl/core/psmd_cfg.sv
// Gain and setpoint configuration registers.
`default_nettype none

module psmd_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [psmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [psmd_pkg::CFG_W-1:0]        cfg_data,
  output psmd_pkg::cfg_t                         cfg
);

  psmd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp     <= psmd_pkg::GAIN_W'(2458);
      cfg_r.ki     <= psmd_pkg::GAIN_W'(205);
      cfg_r.kd     <= psmd_pkg::GAIN_W'(512);
      cfg_r.target <= psmd_pkg::ANGLE_W'(90);
    end else if (cfg_wr_en) begin
      case (psmd_pkg::cfg_reg_t'(cfg_index))
        psmd_pkg::REG_KP:     cfg_r.kp     <= cfg_data;
        psmd_pkg::REG_KI:     cfg_r.ki     <= cfg_data;
        psmd_pkg::REG_KD:     cfg_r.kd     <= cfg_data;
        psmd_pkg::REG_TARGET: cfg_r.target <= cfg_data[psmd_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/core/psmd_err.sv
// Error, derivative difference and saturating error sum; holds controller state.
`default_nettype none

module psmd_err (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire psmd_pkg::pipe_ctl_t                 ctl,
  input  wire logic signed [psmd_pkg::ANGLE_W-1:0] ang,
  input  wire logic signed [psmd_pkg::ANGLE_W-1:0] target,
  output psmd_pkg::stg1_t                          s1
);

  logic signed [psmd_pkg::ERR_W-1:0]  last_error_r;
  logic signed [psmd_pkg::SUM_W-1:0]  error_total_r;
  logic signed [psmd_pkg::ERR_W-1:0]  e_nxt;
  logic signed [psmd_pkg::DIFF_W-1:0] d_nxt;
  logic signed [psmd_pkg::SUM_W:0]    sum_w;
  logic signed [psmd_pkg::SUM_W-1:0]  total_nxt;
  psmd_pkg::stg1_t                    s1_r;

  always_comb begin
    e_nxt = psmd_pkg::ERR_W'(target) - psmd_pkg::ERR_W'(ang);
    d_nxt = psmd_pkg::DIFF_W'(e_nxt) - psmd_pkg::DIFF_W'(last_error_r);
    sum_w = (psmd_pkg::SUM_W+1)'(error_total_r) + (psmd_pkg::SUM_W+1)'(e_nxt);
    if (sum_w[psmd_pkg::SUM_W] != sum_w[psmd_pkg::SUM_W-1]) begin
      total_nxt = {sum_w[psmd_pkg::SUM_W], {(psmd_pkg::SUM_W-1){~sum_w[psmd_pkg::SUM_W]}}};
    end else begin
      total_nxt = sum_w[psmd_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r  <= '0;
      error_total_r <= '0;
    end else if (ctl.ld[1] && ctl.vld[0]) begin
      last_error_r  <= e_nxt;
      error_total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      s1_r.e <= e_nxt;
      s1_r.d <= d_nxt;
      s1_r.s <= total_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

`default_nettype wire

// File: rtl/core/psmd_mul.sv
// Gain multipliers for the proportional, integral and derivative terms.
`default_nettype none

module psmd_mul (
  input  wire logic                clk,
  input  wire psmd_pkg::pipe_ctl_t ctl,
  input  wire psmd_pkg::cfg_t      cfg,
  input  wire psmd_pkg::stg1_t     s1,
  output psmd_pkg::stg2_t          s2
);

  logic signed [psmd_pkg::GAIN_W:0] kp_s;
  logic signed [psmd_pkg::GAIN_W:0] ki_s;
  logic signed [psmd_pkg::GAIN_W:0] kd_s;
  psmd_pkg::stg2_t                  s2_nxt;
  psmd_pkg::stg2_t                  s2_r;

  always_comb begin
    kp_s = signed'({1'b0, cfg.kp});
    ki_s = signed'({1'b0, cfg.ki});
    kd_s = signed'({1'b0, cfg.kd});
    s2_nxt.pk = psmd_pkg::PK_W'(kp_s) * psmd_pkg::PK_W'(s1.e);
    s2_nxt.pd = psmd_pkg::PD_W'(kd_s) * psmd_pkg::PD_W'(s1.d);
    s2_nxt.pi = psmd_pkg::PI_W'(ki_s) * psmd_pkg::PI_W'(s1.s);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

`default_nettype wire

// File: rtl/core/psmd_div.sv
// P+D sum and truncating divide-by-20 of the integral product in two halves.
`default_nettype none

module psmd_div (
  input  wire logic                clk,
  input  wire psmd_pkg::pipe_ctl_t ctl,
  input  wire psmd_pkg::stg2_t     s2,
  output psmd_pkg::stg4_t          s4
);

  localparam int HW = psmd_pkg::HALF_W;

  logic signed [psmd_pkg::A_W-1:0]          pd_x;
  logic signed [psmd_pkg::A_W-1:0]          a_nxt;
  logic [psmd_pkg::PI_W-1:0]                mag_w;
  logic [HW+psmd_pkg::RECIP_W-1:0]          qh_prod;
  logic [psmd_pkg::QH_W-1:0]                qh_nxt;

  logic signed [psmd_pkg::A_W-1:0]          a_r;
  logic                                     neg_r;
  logic                                     big_r;
  logic [HW-1:0]                            nh_r;
  logic [HW-1:0]                            nl_r;
  logic [psmd_pkg::QH_W-1:0]                qh_r;

  logic [HW-1:0]                            rem_w;
  logic [psmd_pkg::T_W-1:0]                 t_w;
  logic [psmd_pkg::T_W+psmd_pkg::RECIP_W-1:0] ql_prod;
  psmd_pkg::stg4_t                          s4_r;

  always_comb begin
    pd_x    = psmd_pkg::A_W'(s2.pd);
    a_nxt   = psmd_pkg::A_W'(s2.pk) + (pd_x <<< 4) + (pd_x <<< 2);
    mag_w   = s2.pi[psmd_pkg::PI_W-1] ? psmd_pkg::PI_W'(-s2.pi) : psmd_pkg::PI_W'(s2.pi);
    qh_prod = (HW+psmd_pkg::RECIP_W)'(mag_w[psmd_pkg::BIG_LO-1:HW+2]) *
              (HW+psmd_pkg::RECIP_W)'(psmd_pkg::RECIP5);
    qh_nxt  = qh_prod[psmd_pkg::RECIP_SH +: psmd_pkg::QH_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      a_r   <= a_nxt;
      neg_r <= s2.pi[psmd_pkg::PI_W-1];
      big_r <= |mag_w[psmd_pkg::MAG_W-1:psmd_pkg::BIG_LO];
      nh_r  <= mag_w[psmd_pkg::BIG_LO-1:HW+2];
      nl_r  <= mag_w[HW+1:2];
      qh_r  <= qh_nxt;
    end
  end

  always_comb begin
    rem_w   = nh_r - (HW'(qh_r) << 2) - HW'(qh_r);
    t_w     = {rem_w[2:0], nl_r};
    ql_prod = (psmd_pkg::T_W+psmd_pkg::RECIP_W)'(t_w) *
              (psmd_pkg::T_W+psmd_pkg::RECIP_W)'(psmd_pkg::RECIP5);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      s4_r.a   <= a_r;
      s4_r.neg <= neg_r;
      s4_r.big <= big_r;
      s4_r.q   <= {qh_r, ql_prod[psmd_pkg::RECIP_SH +: HW]};
    end
  end

  assign s4 = s4_r;

endmodule

`default_nettype wire

// File: rtl/core/psmd_drv.sv
// Drive sum, magnitude clamp and front/back speed registers.
`default_nettype none

module psmd_drv (
  input  wire logic                          clk,
  input  wire psmd_pkg::pipe_ctl_t           ctl,
  input  wire psmd_pkg::stg4_t               s4,
  output logic [psmd_pkg::SPEED_W-1:0]       front_speed,
  output logic [psmd_pkg::SPEED_W-1:0]       back_speed
);

  logic signed [psmd_pkg::DRV_W-1:0] q_x;
  logic signed [psmd_pkg::DRV_W-1:0] drive_nxt;
  logic signed [psmd_pkg::DRV_W-1:0] drive_r;
  logic                              big_r;
  logic                              neg_r;

  logic [psmd_pkg::DRV_W-1:0]        abs_w;
  logic [psmd_pkg::MAGH_W-1:0]       mag_w;
  logic [psmd_pkg::SPEED_W-1:0]      sat_w;
  logic                              pos_w;
  logic [psmd_pkg::SPEED_W-1:0]      front_r;
  logic [psmd_pkg::SPEED_W-1:0]      back_r;

  always_comb begin
    q_x       = signed'({2'b00, s4.q});
    drive_nxt = psmd_pkg::DRV_W'(s4.a) + (s4.neg ? -q_x : q_x);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      drive_r <= drive_nxt;
      big_r   <= s4.big;
      neg_r   <= s4.neg;
    end
  end

  always_comb begin
    abs_w = drive_r[psmd_pkg::DRV_W-1] ? psmd_pkg::DRV_W'(-drive_r)
                                       : psmd_pkg::DRV_W'(drive_r);
    mag_w = abs_w[psmd_pkg::DRV_W-1:psmd_pkg::GAIN_FRAC_BITS];
    if (big_r || (mag_w > psmd_pkg::MAGH_W'(psmd_pkg::SPEED_LIMIT))) begin
      sat_w = psmd_pkg::SPEED_W'(psmd_pkg::SPEED_LIMIT);
    end else begin
      sat_w = mag_w[psmd_pkg::SPEED_W-1:0];
    end
    if (big_r) begin
      pos_w = ~neg_r;
    end else begin
      pos_w = ~drive_r[psmd_pkg::DRV_W-1] && (|drive_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      front_r <= pos_w ? sat_w + psmd_pkg::SPEED_W'(1) : psmd_pkg::SPEED_W'(1);
      back_r  <= pos_w ? psmd_pkg::SPEED_W'(1) : sat_w + psmd_pkg::SPEED_W'(1);
    end
  end

  assign front_speed = front_r;
  assign back_speed  = back_r;

endmodule

`default_nettype wire
